>>> hdl/sacl_pkg.sv
`timescale 1ns / 1ps

package sacl_pkg;

  // access kinds carried on the request side
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;

  // result kinds
  localparam logic [1:0] OUTCOME_HIT   = 2'd0;
  localparam logic [1:0] OUTCOME_FILL  = 2'd1;
  localparam logic [1:0] OUTCOME_EVICT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BITS  = 2'd1;
  localparam logic [1:0] CFG_WAYS_IN_USE = 2'd2;

  // field widths
  localparam int OP_W        = 2;
  localparam int ADDR_W      = 64;
  localparam int CNT_OUT_W   = 32;
  localparam int SB_W        = 3;
  localparam int BB_W        = 6;
  localparam int WU_W        = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (2 + 1 + 3 * CNT_OUT_W);

  localparam logic [WU_W-1:0] WAYS_RESET = 3'd4;

endpackage

>>> hdl/set_assoc_cache_lru_model.sv
`timescale 1ns / 1ps

// channel  | dir | handshake             | contents
// ---------+-----+-----------------------+-------------------------------------------
// s_*      | in  | s_tvalid / s_tready   | access request: kind in tuser, address
// m_*      | out | m_tvalid / m_tready   | outcome, modify flag, running totals
// cfg_*    | in  | cfg_valid / cfg_ready | register index and write data
//
// on accept a request's set row is read from the line state and tag memories
// into registers; the lookup state then compares the ways, picks the line,
// writes the row back and loads the result register
// after reset a clearing pass zeroes the line state memory, one set row a
// cycle, all 2**MAX_SET_BITS rows, before the first request is taken
// a waiting result does not block accepts; a lookup holds while it is unread
module set_assoc_cache_lru_model #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 4,
  parameter int ADDR_BITS    = 64,
  parameter int COUNT_BITS   = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // address [63:0]
  input  logic [sacl_pkg::IN_TDATA_W-1:0]     s_tdata,
  // operation [1:0]
  input  logic [sacl_pkg::OP_W-1:0]           s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // outcome [1:0], modify_hit [2], hit_count [34:3], miss_count [66:35],
  // eviction_count [98:67], zero fill [103:99]
  output logic [sacl_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NUM_SETS  = 1 << MAX_SET_BITS;
  localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int AGE_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WCNT_W    = $clog2(WAYS + 1);
  localparam int TAG_W     = ADDR_BITS;
  localparam int SHIFT_W   = $clog2(MAX_SET_BITS + 64);
  localparam int CNT_EXT_W = (COUNT_BITS > sacl_pkg::CNT_OUT_W) ? COUNT_BITS
                                                                 : sacl_pkg::CNT_OUT_W;
  localparam logic [AGE_W-1:0] AGE_MAX  = AGE_W'(WAYS - 1);
  localparam logic [SET_W-1:0] SET_LAST = SET_W'(NUM_SETS - 1);

  // per set: valid bit and recency rank (0 = most recent) of every way
  typedef struct packed {
    logic [WAYS-1:0]             valid;
    logic [WAYS-1:0][AGE_W-1:0]  age;
  } meta_row_t;

  typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
  endfunction

  // lowest set bit only
  function automatic logic [WAYS-1:0] lowest(input logic [WAYS-1:0] v);
    return v & (~v + WAYS'(1));
  endfunction

  state_t state;
  logic [SET_W-1:0] clr_idx;

  // configuration registers
  logic [sacl_pkg::SB_W-1:0] cfg_set_bits;
  logic [sacl_pkg::BB_W-1:0] cfg_block_bits;
  logic [sacl_pkg::WU_W-1:0] cfg_ways;

  // line state memories
  meta_row_t meta_mem [NUM_SETS];
  tag_row_t  tag_mem  [NUM_SETS];
  meta_row_t meta_rd;
  tag_row_t  tag_rd;

  // request held during lookup
  logic [SET_W-1:0] req_set;
  logic [TAG_W-1:0] req_tag;
  logic             req_modify;

  // totals
  logic [COUNT_BITS-1:0] hit_total;
  logic [COUNT_BITS-1:0] miss_total;
  logic [COUNT_BITS-1:0] evict_total;

  // result register
  logic [1:0]                        out_outcome;
  logic                              out_modify;
  logic [sacl_pkg::CNT_OUT_W-1:0]    out_hits;
  logic [sacl_pkg::CNT_OUT_W-1:0]    out_misses;
  logic [sacl_pkg::CNT_OUT_W-1:0]    out_evicts;

  logic accept;
  logic done;

  // address decode
  logic [SHIFT_W-1:0] sb_eff;
  logic [TAG_W-1:0]   addr_use;
  logic [TAG_W-1:0]   addr_shifted;
  logic [SET_W-1:0]   set_mask;
  logic [SET_W-1:0]   set_idx;
  logic [TAG_W-1:0]   tag_in;
  logic [WCNT_W-1:0]  ways_eff;

  // lookup
  logic [WAYS-1:0]   active;
  logic [WAYS-1:0]   hit_vec;
  logic [WAYS-1:0]   empty_vec;
  logic [WAYS-1:0]   victim_vec;
  logic [WAYS-1:0]   pick_oh;
  logic              found;
  logic              has_empty;
  logic              was_valid;
  logic [AGE_W-1:0]  old_age;
  meta_row_t         meta_next;
  tag_row_t          tag_row_next;
  logic [1:0]        outcome_next;
  logic [COUNT_BITS-1:0] hit_once;
  logic [COUNT_BITS-1:0] hit_next;
  logic [COUNT_BITS-1:0] miss_next;
  logic [COUNT_BITS-1:0] evict_next;
  logic [CNT_EXT_W-1:0]  hit_ext;
  logic [CNT_EXT_W-1:0]  miss_ext;
  logic [CNT_EXT_W-1:0]  evict_ext;

  logic      meta_we;
  logic [SET_W-1:0] meta_waddr;
  meta_row_t meta_wdata;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  // lookup completes once the result register is free or being emptied
  assign done      = (state == ST_LOOKUP) && (!m_tvalid || m_tready);

  // set index and tag from the address; set bits beyond the built range clip
  always_comb begin
    sb_eff       = (int'(cfg_set_bits) > MAX_SET_BITS) ? SHIFT_W'(MAX_SET_BITS)
                                                       : SHIFT_W'(cfg_set_bits);
    addr_use     = s_tdata[TAG_W-1:0];
    addr_shifted = addr_use >> cfg_block_bits;
    set_mask     = ~({SET_W{1'b1}} << sb_eff);
    set_idx      = addr_shifted[SET_W-1:0] & set_mask;
    // a shift at or past the address width leaves a zero tag
    tag_in       = addr_use >> (sb_eff + SHIFT_W'(cfg_block_bits));
  end

  // ways taking part, zero acts as one and too many as all built ways
  always_comb begin
    if (cfg_ways == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (int'(cfg_ways) > WAYS) begin
      ways_eff = WCNT_W'(WAYS);
    end else begin
      ways_eff = WCNT_W'(cfg_ways);
    end
  end

  // way compare, fill and victim choice on the row read at accept
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      active[w]    = (w < int'(ways_eff));
      hit_vec[w]   = active[w] && meta_rd.valid[w] && (tag_rd[w] == req_tag);
      empty_vec[w] = active[w] && !meta_rd.valid[w];
      // oldest line, ties going to the lowest way
      victim_vec[w] = active[w];
      for (int v = 0; v < WAYS; v++) begin
        if (active[v] && (v < w) && !(meta_rd.age[v] < meta_rd.age[w])) begin
          victim_vec[w] = 1'b0;
        end
        if (active[v] && (v > w) && (meta_rd.age[v] > meta_rd.age[w])) begin
          victim_vec[w] = 1'b0;
        end
      end
    end

    found     = |hit_vec;
    has_empty = |empty_vec;
    if (found) begin
      pick_oh      = lowest(hit_vec);
      outcome_next = sacl_pkg::OUTCOME_HIT;
    end else if (has_empty) begin
      pick_oh      = lowest(empty_vec);
      outcome_next = sacl_pkg::OUTCOME_FILL;
    end else begin
      pick_oh      = lowest(victim_vec);
      outcome_next = sacl_pkg::OUTCOME_EVICT;
    end
    was_valid = found || !has_empty;

    old_age = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (pick_oh[w]) begin
        old_age = old_age | meta_rd.age[w];
      end
    end

    // recency update: lines younger than the pick (all lines on a fill) age by one
    meta_next    = meta_rd;
    tag_row_next = tag_rd;
    for (int w = 0; w < WAYS; w++) begin
      if (pick_oh[w]) begin
        meta_next.valid[w] = 1'b1;
        meta_next.age[w]   = '0;
        tag_row_next[w]    = req_tag;
      end else if (active[w] && meta_rd.valid[w] &&
                   (!was_valid || (meta_rd.age[w] < old_age)) &&
                   (meta_rd.age[w] < AGE_MAX)) begin
        meta_next.age[w] = meta_rd.age[w] + AGE_W'(1);
      end
    end

    // a modify adds a second hit for its store half
    hit_once   = found ? sat_inc(hit_total) : hit_total;
    hit_next   = req_modify ? sat_inc(hit_once) : hit_once;
    miss_next  = found ? miss_total : sat_inc(miss_total);
    evict_next = (!found && !has_empty) ? sat_inc(evict_total) : evict_total;

    hit_ext   = CNT_EXT_W'(hit_next);
    miss_ext  = CNT_EXT_W'(miss_next);
    evict_ext = CNT_EXT_W'(evict_next);
  end

  // state memory write port: clearing pass or lookup write-back
  always_comb begin
    meta_we    = (state == ST_CLEAR) || done;
    meta_waddr = (state == ST_CLEAR) ? clr_idx : req_set;
    meta_wdata = (state == ST_CLEAR) ? '0 : meta_next;
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (accept) begin
      meta_rd <= meta_mem[set_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (done && !found) begin
      tag_mem[req_set] <= tag_row_next;
    end
    if (accept) begin
      tag_rd <= tag_mem[set_idx];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_set_bits   <= '0;
      cfg_block_bits <= '0;
      cfg_ways       <= sacl_pkg::WAYS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sacl_pkg::CFG_SET_BITS:    cfg_set_bits   <= cfg_data[sacl_pkg::SB_W-1:0];
        sacl_pkg::CFG_BLOCK_BITS:  cfg_block_bits <= cfg_data[sacl_pkg::BB_W-1:0];
        sacl_pkg::CFG_WAYS_IN_USE: cfg_ways       <= cfg_data[sacl_pkg::WU_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_set    <= set_idx;
      req_tag    <= tag_in;
      req_modify <= (s_tuser == sacl_pkg::OP_MODIFY);
    end
  end

  // sequencer, totals and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_idx     <= '0;
      hit_total   <= '0;
      miss_total  <= '0;
      evict_total <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // a result taken while the next one lands keeps valid high
      if (m_tvalid && m_tready && !done) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + SET_W'(1);
          if (clr_idx == SET_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (done) begin
            state       <= ST_IDLE;
            hit_total   <= hit_next;
            miss_total  <= miss_next;
            evict_total <= evict_next;
            m_tvalid    <= 1'b1;
            out_outcome <= outcome_next;
            out_modify  <= req_modify;
            out_hits    <= hit_ext[sacl_pkg::CNT_OUT_W-1:0];
            out_misses  <= miss_ext[sacl_pkg::CNT_OUT_W-1:0];
            out_evicts  <= evict_ext[sacl_pkg::CNT_OUT_W-1:0];
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {{sacl_pkg::OUT_PAD_W{1'b0}}, out_evicts, out_misses, out_hits,
                    out_modify, out_outcome};

endmodule

>>> tb/sv/tb_set_assoc_cache_lru_model.sv
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_model;

  // geometry of the instance under test, kept at the block defaults
  localparam int MAX_SET_BITS = 6;
  localparam int WAYS         = 4;
  localparam int LINES        = (1 << MAX_SET_BITS) * WAYS;
  localparam int CLK_PERIOD   = 10;
  localparam int PHASES       = 6;
  localparam int PHASE_LEN    = 250;

  localparam int CNT_W  = sacl_pkg::CNT_OUT_W;
  localparam int ADR_W  = sacl_pkg::ADDR_W;
  localparam int KIND_W = sacl_pkg::OP_W;
  localparam int IDX_W  = sacl_pkg::CFG_IDX_W;
  localparam int VAL_W  = sacl_pkg::CFG_DATA_W;

  // register index that the block does not implement
  localparam logic [IDX_W-1:0]  CFG_UNUSED = 2'd3;
  // access kind outside the defined set, treated as a load
  localparam logic [KIND_W-1:0] OP_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]       outcome;
    logic             modify_hit;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evictions;
  } access_result_t;

  // one row of the directed table: either a register write or a request
  typedef struct {
    bit                 is_cfg;
    logic [IDX_W-1:0]   idx;
    logic [VAL_W-1:0]   val;
    logic [KIND_W-1:0]  op;
    logic [ADR_W-1:0]   addr;
    bit                 typed;
    access_result_t     want;
  } stim_row_t;

  logic                                 clk = 1'b0;
  logic                                 rst;
  logic                                 s_tvalid;
  logic                                 s_tready;
  logic [sacl_pkg::IN_TDATA_W-1:0]      s_tdata;
  logic [KIND_W-1:0]                    s_tuser;
  logic                                 m_tvalid;
  logic                                 m_tready;
  logic [sacl_pkg::OUT_TDATA_W-1:0]     m_tdata;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [IDX_W-1:0]                     cfg_index;
  logic [VAL_W-1:0]                     cfg_data;

  // shadow of the tag store: registers, line state and running totals
  logic [sacl_pkg::SB_W-1:0] sb_q;
  logic [sacl_pkg::BB_W-1:0] bb_q;
  logic [sacl_pkg::WU_W-1:0] wu_q;
  bit                     line_ok   [0:LINES-1];
  logic [ADR_W-1:0]       line_tag  [0:LINES-1];
  bit [1:0]               line_rank [0:LINES-1];
  logic [CNT_W-1:0]       hit_tot;
  logic [CNT_W-1:0]       miss_tot;
  logic [CNT_W-1:0]       evict_tot;

  access_result_t         pending_results[$];
  int                     mismatch_count = 0;
  bit                     calm = 1'b0;

  set_assoc_cache_lru_model #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .WAYS         (WAYS),
    .ADDR_BITS    (ADR_W),
    .COUNT_BITS   (CNT_W)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // reset held from time zero, released on a falling edge
  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // hard stop well beyond the slowest legal run, clearing pass included
  initial begin
    #(5_000_000);
    $display("set_assoc_cache_lru_model: mismatch");
    $finish;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns  %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // idle cycles before a request or before taking a result; often none
  function automatic int draw_idle();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 8);
  endfunction

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] total);
    return (total == '1) ? total : total + CNT_W'(1);
  endfunction

  // make one way the most recent; older ways only age if they were newer
  function automatic void promote(int base, int nways, int pick, bit was_valid);
    int prior;
    int v;
    prior = was_valid ? int'(line_rank[base + pick]) : 255;
    for (v = 0; v < nways; v++) begin
      if (v != pick && line_ok[base + v] && int'(line_rank[base + v]) < prior &&
          int'(line_rank[base + v]) < WAYS - 1)
        line_rank[base + v] = line_rank[base + v] + 2'd1;
    end
    line_rank[base + pick] = 2'd0;
  endfunction

  // lookup, fill or evict for one request, updating the shadow state
  function automatic access_result_t predict_access(logic [KIND_W-1:0] op,
                                                    logic [ADR_W-1:0] addr);
    access_result_t res;
    int sb;
    int bb;
    int nways;
    int base;
    int pick;
    int w;
    logic [ADR_W-1:0] set_sel;
    logic [ADR_W-1:0] tag;
    bit found;
    bit has_room;
    sb = (int'(sb_q) > MAX_SET_BITS) ? MAX_SET_BITS : int'(sb_q);
    bb = int'(bb_q);
    nways = (int'(wu_q) == 0) ? 1 : ((int'(wu_q) > WAYS) ? WAYS : int'(wu_q));
    set_sel = (addr >> bb) & ((64'd1 << sb) - 64'd1);
    // index and offset together may swallow the whole address
    tag = (sb + bb >= ADR_W) ? '0 : (addr >> (sb + bb));
    base = int'(set_sel) * WAYS;
    found = 1'b0;
    has_room = 1'b0;
    pick = 0;
    res = '0;
    for (w = 0; w < nways; w++) begin
      if (!found && line_ok[base + w] && line_tag[base + w] == tag) begin
        found = 1'b1;
        pick = w;
      end
    end
    if (found) begin
      hit_tot = bump(hit_tot);
      promote(base, nways, pick, 1'b1);
      res.outcome = sacl_pkg::OUTCOME_HIT;
    end else begin
      miss_tot = bump(miss_tot);
      for (w = 0; w < nways; w++) begin
        if (!has_room && !line_ok[base + w]) begin
          has_room = 1'b1;
          pick = w;
        end
      end
      if (has_room) begin
        res.outcome = sacl_pkg::OUTCOME_FILL;
        promote(base, nways, pick, 1'b0);
      end else begin
        // oldest way wins, lowest index on a tie
        pick = 0;
        for (w = 1; w < nways; w++)
          if (line_rank[base + w] > line_rank[base + pick]) pick = w;
        res.outcome = sacl_pkg::OUTCOME_EVICT;
        evict_tot = bump(evict_tot);
        promote(base, nways, pick, 1'b1);
      end
      line_ok[base + pick]  = 1'b1;
      line_tag[base + pick] = tag;
    end
    // the store half of a modify always hits
    if (op == sacl_pkg::OP_MODIFY) hit_tot = bump(hit_tot);
    res.modify_hit = (op == sacl_pkg::OP_MODIFY);
    res.hits       = hit_tot;
    res.misses     = miss_tot;
    res.evictions  = evict_tot;
    return res;
  endfunction

  // drive one request; the expectation is queued on the accepting edge
  task automatic send_access(logic [KIND_W-1:0] op, logic [ADR_W-1:0] addr,
                             bit typed, access_result_t typed_want);
    int gap;
    access_result_t predicted;
    gap = draw_idle();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= addr;
    s_tuser  <= op;
    do @(posedge clk); while (s_tready !== 1'b1);
    predicted = predict_access(op, addr);
    pending_results.push_back(typed ? typed_want : predicted);
    @(negedge clk);
  endtask

  // stop sending and let every outstanding request come back
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // leaves cfg_valid high so that writes can follow back to back
  task automatic write_register(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      sacl_pkg::CFG_SET_BITS:    sb_q = val[sacl_pkg::SB_W-1:0];
      sacl_pkg::CFG_BLOCK_BITS:  bb_q = val[sacl_pkg::BB_W-1:0];
      sacl_pkg::CFG_WAYS_IN_USE: wu_q = val[sacl_pkg::WU_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic stim_row_t access_row(logic [KIND_W-1:0] op, logic [ADR_W-1:0] addr);
    stim_row_t r;
    r = '{default: '0};
    r.op = op;
    r.addr = addr;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [KIND_W-1:0] op, logic [ADR_W-1:0] addr,
                                          logic [1:0] outcome, logic mod,
                                          int h, int m, int e);
    stim_row_t r;
    r = access_row(op, addr);
    r.typed = 1'b1;
    r.want = '{outcome, mod, h, m, e};
    return r;
  endfunction

  function automatic stim_row_t config_row(logic [IDX_W-1:0] idx,
                                           logic [VAL_W-1:0] val);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  // result side: random back-pressure, drawn afresh for each result
  initial begin : result_sink
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_idle();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  // result checker: every accepted result against the oldest expectation
  access_result_t seen;
  access_result_t oldest;

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      seen.outcome    = m_tdata[1:0];
      seen.modify_hit = m_tdata[2];
      seen.hits       = m_tdata[3 +: CNT_W];
      seen.misses     = m_tdata[3 + CNT_W +: CNT_W];
      seen.evictions  = m_tdata[3 + 2 * CNT_W +: CNT_W];
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding", m_tdata[63:0], '0);
      end else begin
        oldest = pending_results.pop_front();
        if (seen.outcome !== oldest.outcome)
          report_mismatch("outcome", 64'(seen.outcome), 64'(oldest.outcome));
        if (seen.modify_hit !== oldest.modify_hit)
          report_mismatch("modify_hit", 64'(seen.modify_hit), 64'(oldest.modify_hit));
        if (seen.hits !== oldest.hits)
          report_mismatch("hit_count", 64'(seen.hits), 64'(oldest.hits));
        if (seen.misses !== oldest.misses)
          report_mismatch("miss_count", 64'(seen.misses), 64'(oldest.misses));
        if (seen.evictions !== oldest.evictions)
          report_mismatch("eviction_count", 64'(seen.evictions), 64'(oldest.evictions));
        if (m_tdata[sacl_pkg::OUT_TDATA_W-1 -: sacl_pkg::OUT_PAD_W] !== '0)
          report_mismatch("zero fill",
                          64'(m_tdata[sacl_pkg::OUT_TDATA_W-1 -: sacl_pkg::OUT_PAD_W]),
                          '0);
      end
    end
  end

  initial begin : stimulus
    stim_row_t directed[$];
    logic [ADR_W-1:0] tag_pool[6];
    logic [ADR_W-1:0] set_pool[3];
    logic [ADR_W-1:0] addr;
    logic [ADR_W-1:0] set_mask;
    logic [ADR_W-1:0] off_mask;
    logic [sacl_pkg::SB_W-1:0] sb_v;
    logic [sacl_pkg::BB_W-1:0] bb_v;
    logic [sacl_pkg::WU_W-1:0] wu_v;
    int sbe;
    int n_tags;
    int n_sets;
    int i;
    int p;
    int n;
    bit prev_cfg;

    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    sb_q      = '0;
    bb_q      = '0;
    wu_q      = sacl_pkg::WAYS_RESET;
    hit_tot   = '0;
    miss_tot  = '0;
    evict_tot = '0;

    // after reset: one set, tag is the whole address, four ways
    directed.push_back(known_row(sacl_pkg::OP_LOAD, 64'd0, sacl_pkg::OUTCOME_FILL,
                                 1'b0, 0, 1, 0));
    directed.push_back(known_row(sacl_pkg::OP_LOAD, 64'd0, sacl_pkg::OUTCOME_HIT,
                                 1'b0, 1, 1, 0));
    directed.push_back(known_row(sacl_pkg::OP_STORE, '1, sacl_pkg::OUTCOME_FILL,
                                 1'b0, 1, 2, 0));
    directed.push_back(known_row(sacl_pkg::OP_MODIFY, 64'd0, sacl_pkg::OUTCOME_HIT,
                                 1'b1, 3, 2, 0));
    // unknown kind behaves as a plain load
    directed.push_back(known_row(OP_UNKNOWN, 64'd1, sacl_pkg::OUTCOME_FILL,
                                 1'b0, 3, 3, 0));
    directed.push_back(known_row(sacl_pkg::OP_MODIFY, 64'd2, sacl_pkg::OUTCOME_FILL,
                                 1'b1, 4, 4, 0));
    // set full: the all-ones line is the oldest and goes
    directed.push_back(known_row(sacl_pkg::OP_LOAD, 64'd3, sacl_pkg::OUTCOME_EVICT,
                                 1'b0, 4, 5, 1));
    // a single way in use, then zero ways (treated as one), then too many
    directed.push_back(config_row(sacl_pkg::CFG_WAYS_IN_USE, 6'd1));
    directed.push_back(access_row(sacl_pkg::OP_LOAD, 64'd0));
    directed.push_back(access_row(sacl_pkg::OP_STORE, 64'd5));
    directed.push_back(config_row(sacl_pkg::CFG_WAYS_IN_USE, 6'd0));
    directed.push_back(access_row(sacl_pkg::OP_LOAD, 64'd0));
    directed.push_back(config_row(sacl_pkg::CFG_WAYS_IN_USE, 6'd7));
    directed.push_back(access_row(sacl_pkg::OP_LOAD, 64'd3));
    directed.push_back(access_row(sacl_pkg::OP_LOAD, '1));
    // oversized set index clamps to six bits; index and offset cover the address
    directed.push_back(config_row(sacl_pkg::CFG_SET_BITS, 6'h3F));
    directed.push_back(config_row(sacl_pkg::CFG_BLOCK_BITS, 6'd58));
    directed.push_back(access_row(sacl_pkg::OP_LOAD, '1));
    directed.push_back(access_row(sacl_pkg::OP_LOAD, 64'h03FF_FFFF_FFFF_FFFF));
    directed.push_back(access_row(sacl_pkg::OP_MODIFY, 64'hFC00_0000_0000_0000));
    directed.push_back(config_row(sacl_pkg::CFG_BLOCK_BITS, 6'd63));
    directed.push_back(access_row(sacl_pkg::OP_LOAD, 64'h8000_0000_0000_0000));
    directed.push_back(access_row(sacl_pkg::OP_LOAD, 64'h7FFF_FFFF_FFFF_FFFF));
    // write to an index with no register behind it changes nothing
    directed.push_back(config_row(CFG_UNUSED, 6'h3F));
    directed.push_back(access_row(sacl_pkg::OP_STORE, 64'h8000_0000_0000_0001));

    @(negedge clk);
    while (rst) @(negedge clk);

    prev_cfg = 1'b0;
    for (i = 0; i < directed.size(); i++) begin
      if (directed[i].is_cfg) begin
        // registers only change with nothing in flight
        if (!prev_cfg) drain_pipeline();
        write_register(directed[i].idx, directed[i].val);
      end else begin
        if (prev_cfg) cfg_valid <= 1'b0;
        send_access(directed[i].op, directed[i].addr, directed[i].typed, directed[i].want);
      end
      prev_cfg = directed[i].is_cfg;
    end

    // random phases, each under its own geometry; the drain before each
    // reconfiguration also lets every result come home before more requests
    for (p = 0; p < PHASES; p++) begin
      drain_pipeline();
      sb_v = (p == 0) ? 3'd7 : 3'($urandom_range(0, 7));
      if (p == 0)      bb_v = 6'd63;
      else if (p == 1) bb_v = 6'd0;
      else if ($urandom_range(0, 3) == 0) bb_v = 6'($urandom_range(0, 63));
      else             bb_v = 6'($urandom_range(0, 8));
      wu_v = (p == 2) ? 3'd0 : 3'($urandom_range(0, 7));
      // upper data bits are unused for the narrow registers
      write_register(sacl_pkg::CFG_SET_BITS, {3'($urandom), sb_v});
      write_register(sacl_pkg::CFG_BLOCK_BITS, bb_v);
      write_register(sacl_pkg::CFG_WAYS_IN_USE, {3'($urandom), wu_v});
      if ($urandom_range(0, 1) == 1) write_register(CFG_UNUSED, 6'($urandom));
      cfg_valid <= 1'b0;
      calm = (p % 3 == 1);

      // a few tags over a few sets so that lines are hit, refilled and evicted
      sbe = (int'(sb_v) > MAX_SET_BITS) ? MAX_SET_BITS : int'(sb_v);
      set_mask = (64'd1 << sbe) - 64'd1;
      off_mask = (64'd1 << bb_v) - 64'd1;
      n_tags = $urandom_range(2, 6);
      n_sets = $urandom_range(1, 3);
      foreach (tag_pool[k]) tag_pool[k] = {$urandom, $urandom};
      foreach (set_pool[k]) set_pool[k] = {$urandom, $urandom};

      for (n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          addr = {$urandom, $urandom};
        end else begin
          addr = (tag_pool[$urandom_range(0, n_tags - 1)] << (sbe + int'(bb_v))) |
                 ((set_pool[$urandom_range(0, n_sets - 1)] & set_mask) << bb_v) |
                 ({$urandom, $urandom} & off_mask);
        end
        send_access(KIND_W'($urandom_range(0, 3)), addr, 1'b0, '0);
      end
    end

    drain_pipeline();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0)
      $display("set_assoc_cache_lru_model: match");
    else
      $display("set_assoc_cache_lru_model: mismatch");
    $finish;
  end

endmodule

>>> sim.f
hdl/sacl_pkg.sv
hdl/set_assoc_cache_lru_model.sv
tb/sv/tb_set_assoc_cache_lru_model.sv
